// File: design/pt3d_pkg.sv
// Shared types and constants for the 3D point transform.
// Request and result payloads, configuration view, per-axis datapath control.
// No dependencies.
package pt3d_pkg;

	// Configuration address and data widths
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_OP_MODE = 3'd0;
	localparam logic [2:0] REG_COEF_A  = 3'd1;
	localparam logic [2:0] REG_COEF_B  = 3'd2;
	localparam logic [2:0] REG_VEC_X   = 3'd3;
	localparam logic [2:0] REG_VEC_Y   = 3'd4;
	localparam logic [2:0] REG_VEC_Z   = 3'd5;

	// Operation codes
	localparam logic [2:0] MODE_PASS      = 3'd0;
	localparam logic [2:0] MODE_TRANSLATE = 3'd1;
	localparam logic [2:0] MODE_SCALE     = 3'd2;
	localparam logic [2:0] MODE_ROT_X     = 3'd3;
	localparam logic [2:0] MODE_ROT_Y     = 3'd4;
	localparam logic [2:0] MODE_ROT_Z     = 3'd5;

	// Q2.14 unit and rounding constant
	localparam logic signed [16:0] COEF_ONE   = 17'sd16384;
	localparam logic signed [50:0] ROUND_HALF = 51'sd8192;
	localparam int                 Q_FRAC     = 14;

	localparam logic signed [31:0] COEF_A_RESET = 32'sd16384;
	localparam logic signed [31:0] COORD_MAX    = 32'sh7fffffff;
	localparam logic signed [31:0] COORD_MIN    = 32'sh80000000;

	typedef struct packed {
		logic        [15:0] vertex_id;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} point_t;

	typedef struct packed {
		logic        [15:0] out_id;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               clipped;
	} result_t;

	typedef struct packed {
		logic        [2:0]  op_mode;
		logic signed [15:0] coef_a;
		logic signed [15:0] coef_b;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
	} cfg_t;

	// Control and operands for one axis: base + round((d_self*coef1 + d_other*coef2) / 2^14)
	// when use_prod is set, else base alone.
	typedef struct packed {
		logic               use_prod;
		logic signed [32:0] d_self;
		logic signed [32:0] d_other;
		logic signed [16:0] coef1;
		logic signed [16:0] coef2;
		logic signed [32:0] base;
	} axis_op_t;

endpackage

// File: design/pt3d_regs.sv
// Configuration register file on an APB-style port.
// Depends on pt3d_pkg for register indexes and the cfg_t view.
module pt3d_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pt3d_pkg::ADDR_W-1:0]   paddr,
	input  logic [pt3d_pkg::DATA_W-1:0]   pwdata,
	output logic [pt3d_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output pt3d_pkg::cfg_t                cfg
);
	import pt3d_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.op_mode <= MODE_PASS;
			cfg_q.coef_a  <= COEF_A_RESET[15:0];
			cfg_q.coef_b  <= '0;
			cfg_q.vec_x   <= '0;
			cfg_q.vec_y   <= '0;
			cfg_q.vec_z   <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_OP_MODE: cfg_q.op_mode <= pwdata[2:0];
				REG_COEF_A:  cfg_q.coef_a  <= pwdata[15:0];
				REG_COEF_B:  cfg_q.coef_b  <= pwdata[15:0];
				REG_VEC_X:   cfg_q.vec_x   <= pwdata;
				REG_VEC_Y:   cfg_q.vec_y   <= pwdata;
				REG_VEC_Z:   cfg_q.vec_z   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_OP_MODE: prdata = {29'd0, cfg_q.op_mode};
			REG_COEF_A:  prdata = {{16{cfg_q.coef_a[15]}}, cfg_q.coef_a};
			REG_COEF_B:  prdata = {{16{cfg_q.coef_b[15]}}, cfg_q.coef_b};
			REG_VEC_X:   prdata = cfg_q.vec_x;
			REG_VEC_Y:   prdata = cfg_q.vec_y;
			REG_VEC_Z:   prdata = cfg_q.vec_z;
			default:     prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: design/pt3d_axis.sv
// One coordinate lane: two products registered, then sum, round, offset and saturate.
// Depends on pt3d_pkg for axis_op_t and fixed-point constants.
module pt3d_axis (
	input  logic                    clk,
	input  pt3d_pkg::axis_op_t      op,
	output logic signed [31:0]      res,
	output logic                    clip
);
	import pt3d_pkg::*;

	logic signed [49:0] prod_a_s2, prod_b_s2;
	logic signed [32:0] base_s2;
	logic               use_prod_s2;

	logic signed [49:0] prod_a, prod_b;
	logic signed [50:0] sum;
	logic signed [36:0] rounded;
	logic signed [37:0] total;
	logic               over, under;
	logic signed [31:0] res_q;
	logic               clip_q;

	assign prod_a = op.d_self * op.coef1;
	assign prod_b = op.d_other * op.coef2;

	always_ff @(posedge clk) begin
		prod_a_s2   <= prod_a;
		prod_b_s2   <= prod_b;
		base_s2     <= op.base;
		use_prod_s2 <= op.use_prod;
	end

	always_comb begin
		sum     = $signed({prod_a_s2[49], prod_a_s2}) + $signed({prod_b_s2[49], prod_b_s2})
		          + ROUND_HALF;
		rounded = sum[50:Q_FRAC];
		if (use_prod_s2)
			total = $signed({{5{base_s2[32]}}, base_s2}) + $signed({rounded[36], rounded});
		else
			total = $signed({{5{base_s2[32]}}, base_s2});
		over  = !total[37] && (|total[36:31]);
		under = total[37] && !(&total[36:31]);
	end

	always_ff @(posedge clk) begin
		if (over)
			res_q <= COORD_MAX;
		else if (under)
			res_q <= COORD_MIN;
		else
			res_q <= total[31:0];
		clip_q <= over | under;
	end

	assign res  = res_q;
	assign clip = clip_q;

	// A clipped lane must sit on one of the range limits
	assert property (@(posedge clk) clip_q |-> (res_q == COORD_MAX || res_q == COORD_MIN))
		else $error("clipped lane not at a range limit");

endmodule

// File: design/point_transform_3d.sv
// Top level of the 3D point transform: request register, operand select, three axis lanes.
// Depends on pt3d_pkg, pt3d_regs and pt3d_axis.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------
//  request   | start, busy            | point  (vertex_id, point_x/y/z)
//  result    | done (one-cycle strobe)| result (out_id, out_x/y/z, clipped)
//  config    | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
// A request taken at an edge has its result on the ports, with done high, once the result
// register holds it. The stages are the request register, the product register inside
// each lane, and the result register.
// busy never rises: a new request is taken every cycle, one result per request.
// The receiver cannot stall; each result is valid for exactly one cycle.
// arst_n clears the pipeline valid flags and loads register reset values.
module point_transform_3d (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  pt3d_pkg::point_t              point,
	output logic                          done,
	output pt3d_pkg::result_t             result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pt3d_pkg::ADDR_W-1:0]   paddr,
	input  logic [pt3d_pkg::DATA_W-1:0]   pwdata,
	output logic [pt3d_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import pt3d_pkg::*;

	cfg_t   cfg;
	point_t point_s1;
	logic   valid_s1, valid_s2, valid_s3;
	logic [15:0] id_s2, id_s3;

	// Extended coordinates, centers, deltas and coefficients
	logic signed [32:0] px, py, pz, cx, cy, cz, dx, dy, dz;
	logic signed [16:0] k_scale, ca, cb, cb_neg;
	axis_op_t           op_x, op_y, op_z;

	logic signed [31:0] res_x, res_y, res_z;
	logic               clip_x, clip_y, clip_z;

	assign busy = 1'b0;

	pt3d_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Request register: capture each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy)
			point_s1 <= point;
		id_s2 <= point_s1.vertex_id;
		id_s3 <= id_s2;
	end

	always_comb begin
		px = {point_s1.point_x[31], point_s1.point_x};
		py = {point_s1.point_y[31], point_s1.point_y};
		pz = {point_s1.point_z[31], point_s1.point_z};
		cx = {cfg.vec_x[31], cfg.vec_x};
		cy = {cfg.vec_y[31], cfg.vec_y};
		cz = {cfg.vec_z[31], cfg.vec_z};
		// Deltas from the center fit in 33 bits
		dx = px - cx;
		dy = py - cy;
		dz = pz - cz;
		// Scale factor is 1 + s; fits 17 bits signed
		ca      = {cfg.coef_a[15], cfg.coef_a};
		cb      = {cfg.coef_b[15], cfg.coef_b};
		k_scale = ca + COEF_ONE;
		cb_neg  = -cb;

		// Default: pass the coordinate through untouched
		op_x = '{use_prod: 1'b0, d_self: dx, d_other: '0, coef1: ca, coef2: '0, base: px};
		op_y = '{use_prod: 1'b0, d_self: dy, d_other: '0, coef1: ca, coef2: '0, base: py};
		op_z = '{use_prod: 1'b0, d_self: dz, d_other: '0, coef1: ca, coef2: '0, base: pz};

		case (cfg.op_mode)
			MODE_TRANSLATE: begin
				op_x.base = px + cx;
				op_y.base = py + cy;
				op_z.base = pz + cz;
			end
			MODE_SCALE: begin
				op_x.use_prod = 1'b1; op_x.coef1 = k_scale; op_x.base = cx;
				op_y.use_prod = 1'b1; op_y.coef1 = k_scale; op_y.base = cy;
				op_z.use_prod = 1'b1; op_z.coef1 = k_scale; op_z.base = cz;
			end
			MODE_ROT_X: begin
				// y' = dy*cos + dz*sin, z' = dz*cos - dy*sin
				op_y.use_prod = 1'b1; op_y.d_other = dz; op_y.coef2 = cb;     op_y.base = cy;
				op_z.use_prod = 1'b1; op_z.d_other = dy; op_z.coef2 = cb_neg; op_z.base = cz;
			end
			MODE_ROT_Y: begin
				// x' = dx*cos + dz*sin, z' = dz*cos - dx*sin
				op_x.use_prod = 1'b1; op_x.d_other = dz; op_x.coef2 = cb;     op_x.base = cx;
				op_z.use_prod = 1'b1; op_z.d_other = dx; op_z.coef2 = cb_neg; op_z.base = cz;
			end
			MODE_ROT_Z: begin
				// x' = dx*cos - dy*sin, y' = dy*cos + dx*sin
				op_x.use_prod = 1'b1; op_x.d_other = dy; op_x.coef2 = cb_neg; op_x.base = cx;
				op_y.use_prod = 1'b1; op_y.d_other = dx; op_y.coef2 = cb;     op_y.base = cy;
			end
			default: ;
		endcase
	end

	pt3d_axis u_axis_x (.clk(clk), .op(op_x), .res(res_x), .clip(clip_x));
	pt3d_axis u_axis_y (.clk(clk), .op(op_y), .res(res_y), .clip(clip_y));
	pt3d_axis u_axis_z (.clk(clk), .op(op_z), .res(res_z), .clip(clip_z));

	// Result register lives in the lanes; drive the strobe from the valid chain
	assign done           = valid_s3;
	assign result.out_id  = id_s3;
	assign result.out_x   = res_x;
	assign result.out_y   = res_y;
	assign result.out_z   = res_z;
	assign result.clipped = clip_x | clip_y | clip_z;

	// Every accepted request yields its result with a done strobe
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |-> ##3 done)
		else $error("accepted request produced no result");

	// The vertex id comes out with the result of its own request
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 (result.out_id == $past(point.vertex_id, 3)))
		else $error("vertex id out of order");

	// No result appears unless the valid chain carried a request ahead of it
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 == 1'b0) |=> !done)
		else $error("result strobe without request");

endmodule
